// ----- hw/rtl/ost_pkg.sv -----
// ============================================================================
// ost_pkg - shared types and constants for the one-shot timer table
// Request and result payloads, function and result codes, memory port bundle.
// ============================================================================
package ost_pkg;

    localparam int SLOT_W      = 4;
    localparam int QUEUE_DEPTH = 2 ** SLOT_W;
    localparam int PTR_W       = SLOT_W;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TICK_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int KIND_W      = 2;

    // function codes of a request
    localparam logic [FUNC_W-1:0] FUNC_REGISTER   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNREGISTER = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_START      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_STOP       = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SET_ENABLE = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd5;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] value;
        logic              enable;
    } ost_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot_out;
        logic              last;
    } ost_rsp_t;

    // controller to slot memories: one shared write address, one read address
    typedef struct packed {
        logic              dl_we;
        logic              en_we;
        logic [PTR_W-1:0]  waddr;
        logic [TICK_W-1:0] dl_wdata;
        logic              en_wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } ost_mem_req_t;

endpackage

// ----- hw/rtl/one_shot_timer_table.sv -----
// ============================================================================
// one_shot_timer_table - ring of one-shot timer slots
// Register, unregister, start, stop, enable and tick requests over a ring of
// timer slots whose deadlines and enable flags live in two slot memories.
// ============================================================================
// Issue a request by raising start with the payload on req; it is taken at the
// clock edge where start is high and busy is low. Every result shows on rsp
// for exactly one cycle with rsp_valid high, and rsp.last marks the final
// result of a request. The receiver cannot stall: capture each result in the
// cycle it appears. Register, unregister, start, stop, set enable and unknown
// codes answer in the cycle after acceptance; busy stays low, so such
// requests may be issued back to back. A tick stores the new tick value and
// scans the occupied slots from head to tail, one slot memory read a cycle,
// with compare and write-back of a cleared deadline in the cycle after the
// read. It holds busy through its scan, drain and done states (not at all on
// an empty ring), gives a fire result for each expired, enabled, armed slot,
// and ends with a done result. A register on a full ring or an unregister on
// an empty ring is refused. Slot numbers are ring positions; start, stop and
// set enable write the named slot whether or not it is currently occupied.
// ============================================================================
module one_shot_timer_table
    import ost_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ost_req_t req,
    output logic     busy,
    output logic     rsp_valid,
    output ost_rsp_t rsp
);

    ost_mem_req_t      mem_req;
    logic [TICK_W-1:0] dl_rdata;
    logic              en_rdata;

    // sequence requests, own the ring pointers and the current tick
    ost_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .mem_req   (mem_req),
        .dl_rdata  (dl_rdata),
        .en_rdata  (en_rdata),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // hold the deadline of each slot; zero means stopped
    ost_ram #(
        .WIDTH (TICK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_deadline_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_req.dl_we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.dl_wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (dl_rdata)
    );

    // hold the enable flag of each slot
    ost_ram #(
        .WIDTH (1),
        .DEPTH (QUEUE_DEPTH)
    ) u_enable_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_req.en_we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.en_wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (en_rdata)
    );

    // every non-tick request answers with its final result in the next cycle
    a_cmd_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.func != FUNC_TICK) |=> rsp_valid && rsp.last)
        else $error("command result missing in the cycle after acceptance");

    // fire results only come out of a running scan
    a_fire_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind == KIND_FIRE) |-> busy && !rsp.last)
        else $error("fire result outside a tick scan");

    // the final result of any request leaves the block ready for the next
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.last |-> !busy)
        else $error("final result while still busy");

endmodule

// ----- hw/rtl/ost_ram.sv -----
// ============================================================================
// ost_ram - slot memory with registered read and per-entry valid bits
// One write and one read port; an entry never written since reset reads zero.
// ============================================================================
module ost_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
        end
    end

    // valid bits stand in for the zero reset of the array
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ost_ctrl.sv -----
// ============================================================================
// ost_ctrl - command decode, ring pointers and tick scan sequencer
// Runs the non-tick commands and the read/compare/write-back pass of a tick.
// ============================================================================
module ost_ctrl
    import ost_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ost_req_t            req,
    output logic                busy,
    output ost_mem_req_t        mem_req,
    input  logic [TICK_W-1:0]   dl_rdata,
    input  logic                en_rdata,
    output logic                rsp_valid,
    output ost_rsp_t            rsp
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [PTR_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pipe_valid_reg, pipe_valid_next;
    logic [PTR_W-1:0]  pipe_pos_reg, pipe_pos_next;
    logic              rsp_valid_reg, rsp_valid_next;
    ost_rsp_t          rsp_reg, rsp_next;
    logic              accept;
    logic              fire;

    assign accept = start && (state_reg == ST_IDLE);
    assign fire   = pipe_valid_reg && en_rdata && (dl_rdata != '0) && (tick_reg > dl_rdata);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        tick_next       = tick_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        pipe_valid_next = 1'b0;
        pipe_pos_next   = pipe_pos_reg;
        rsp_valid_next  = 1'b0;
        rsp_next        = '{kind: KIND_ACK, slot_out: '0, last: 1'b1};
        mem_req         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next = 1'b1;
                    unique case (req.func)
                        FUNC_REGISTER:
                        begin
                            if (occ_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                rsp_next.kind = KIND_REFUSED;
                            end
                            else
                            begin
                                mem_req.dl_we    = 1'b1;
                                mem_req.en_we    = 1'b1;
                                mem_req.waddr    = tail_reg;
                                mem_req.en_wdata = req.enable;
                                rsp_next.slot_out = tail_reg;
                                tail_next        = tail_reg + 1'b1;
                                occ_next         = occ_reg + 1'b1;
                            end
                        end
                        FUNC_UNREGISTER:
                        begin
                            if (occ_reg == '0)
                            begin
                                rsp_next.kind = KIND_REFUSED;
                            end
                            else
                            begin
                                rsp_next.slot_out = head_reg;
                                head_next         = head_reg + 1'b1;
                                occ_next          = occ_reg - 1'b1;
                            end
                        end
                        FUNC_START:
                        begin
                            mem_req.dl_we     = 1'b1;
                            mem_req.waddr     = req.slot;
                            mem_req.dl_wdata  = tick_reg + req.value;
                            rsp_next.slot_out = req.slot;
                        end
                        FUNC_STOP:
                        begin
                            mem_req.dl_we     = 1'b1;
                            mem_req.waddr     = req.slot;
                            rsp_next.slot_out = req.slot;
                        end
                        FUNC_SET_ENABLE:
                        begin
                            mem_req.en_we     = 1'b1;
                            mem_req.waddr     = req.slot;
                            mem_req.en_wdata  = req.enable;
                            rsp_next.slot_out = req.slot;
                        end
                        FUNC_TICK:
                        begin
                            tick_next = req.value;
                            pos_next  = head_reg;
                            cnt_next  = occ_reg;
                            // empty ring: answer done at once
                            if (occ_reg != '0)
                            begin
                                rsp_valid_next = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            // unknown codes: plain ack, no state change
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // issue one slot read per cycle, head to tail
                mem_req.re      = 1'b1;
                mem_req.raddr   = pos_reg;
                pipe_valid_next = 1'b1;
                pipe_pos_next   = pos_reg;
                pos_next        = pos_reg + 1'b1;
                cnt_next        = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                rsp_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // evaluate the slot read last cycle: disarm and report an expired timer
        if (fire)
        begin
            mem_req.dl_we    = 1'b1;
            mem_req.waddr    = pipe_pos_reg;
            mem_req.dl_wdata = '0;
            rsp_valid_next   = 1'b1;
            rsp_next         = '{kind: KIND_FIRE, slot_out: pipe_pos_reg, last: 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            occ_reg        <= '0;
            tick_reg       <= '0;
            cnt_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            occ_reg        <= occ_next;
            tick_reg       <= tick_next;
            cnt_reg        <= cnt_next;
            pipe_valid_reg <= pipe_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        pipe_pos_reg <= pipe_pos_next;
        rsp_reg      <= rsp_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- sim/tb_one_shot_timer_table.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_one_shot_timer_table - self-checking bench for the one-shot timer table
// Walks a short table of directed requests (empty ring, wrapping deadlines,
// unused slots, unknown codes), then runs random request sequences built
// around fill, arm, tick and drain. Every result is compared field by field
// against a typed-in result or an in-bench predictor of the slot ring.
// ============================================================================
module tb_one_shot_timer_table;
    import ost_pkg::*;

    // Function codes the block answers with a plain ack and no state change.
    localparam logic [FUNC_W-1:0] FUNC_RSVD_A = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_B = 3'd7;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    // A tick on a full ring holds busy through a scan of every slot.
    localparam int SCAN_SETTLE  = QUEUE_DEPTH + 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int GAP_ITEMS    = 400;
    localparam int TOTAL_ITEMS  = 465;

    typedef struct packed {
        ost_req_t rq;
        logic     has_lit;
        ost_rsp_t lit;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    ost_req_t req;
    logic     busy;
    logic     rsp_valid;
    ost_rsp_t rsp;

    // Predictor copy of the slot ring.
    logic [TICK_W-1:0] tbl_deadline [QUEUE_DEPTH];
    logic              tbl_enabled  [QUEUE_DEPTH];
    logic [PTR_W-1:0]  ring_head;
    logic [PTR_W-1:0]  ring_tail;
    logic [CNT_W-1:0]  ring_count;
    logic [TICK_W-1:0] tick_now;

    ost_rsp_t predicted_rsp [$];
    ost_rsp_t expected_rsp  [$];
    dir_row_t dir_rows      [$];
    ost_rsp_t want;

    int mismatch_count;
    int cycle_count;
    int items_sent;
    int ticks_sent;
    int full_ticks;
    int fires_seen;
    int refusals_seen;

    one_shot_timer_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Helpers to build requests and results
    // ------------------------------------------------------------------------
    function automatic ost_req_t mk_req(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                                        input logic [TICK_W-1:0] v, input logic e);
        ost_req_t r;
        r.func   = f;
        r.slot   = s;
        r.value  = v;
        r.enable = e;
        return r;
    endfunction

    function automatic ost_rsp_t mk_rsp(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] s,
                                        input logic l);
        ost_rsp_t r;
        r.kind     = k;
        r.slot_out = s;
        r.last     = l;
        return r;
    endfunction

    // Random field values at the width of their fields.
    function automatic logic [SLOT_W-1:0] rnd_slot();
        return SLOT_W'($urandom_range(0, QUEUE_DEPTH - 1));
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [FUNC_W-1:0] rnd_func();
        return FUNC_W'($urandom_range(0, 7));
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: advance the ring copy by one request and leave its results
    // in predicted_rsp, oldest first.
    // ------------------------------------------------------------------------
    function automatic void timer_table_predict(input ost_req_t r);
        logic [PTR_W-1:0] pos;
        predicted_rsp.delete();
        case (r.func)
            FUNC_REGISTER:
                if (ring_count == QUEUE_DEPTH)
                    predicted_rsp.push_back(mk_rsp(KIND_REFUSED, '0, 1'b1));
                else
                begin
                    tbl_enabled[ring_tail]  = r.enable;
                    tbl_deadline[ring_tail] = '0;
                    predicted_rsp.push_back(mk_rsp(KIND_ACK, ring_tail, 1'b1));
                    ring_tail  = ring_tail + 1'b1;
                    ring_count = ring_count + 1'b1;
                end
            FUNC_UNREGISTER:
                if (ring_count == 0)
                    predicted_rsp.push_back(mk_rsp(KIND_REFUSED, '0, 1'b1));
                else
                begin
                    predicted_rsp.push_back(mk_rsp(KIND_ACK, ring_head, 1'b1));
                    ring_head  = ring_head + 1'b1;
                    ring_count = ring_count - 1'b1;
                end
            FUNC_START:
            begin
                // A sum that wraps to zero leaves the slot stopped by itself.
                tbl_deadline[r.slot] = tick_now + r.value;
                predicted_rsp.push_back(mk_rsp(KIND_ACK, r.slot, 1'b1));
            end
            FUNC_STOP:
            begin
                tbl_deadline[r.slot] = '0;
                predicted_rsp.push_back(mk_rsp(KIND_ACK, r.slot, 1'b1));
            end
            FUNC_SET_ENABLE:
            begin
                tbl_enabled[r.slot] = r.enable;
                predicted_rsp.push_back(mk_rsp(KIND_ACK, r.slot, 1'b1));
            end
            FUNC_TICK:
            begin
                tick_now = r.value;
                pos = ring_head;
                for (int i = 0; i < ring_count; i++)
                begin
                    if (tbl_enabled[pos] && tbl_deadline[pos] != 0 && tick_now > tbl_deadline[pos])
                    begin
                        tbl_deadline[pos] = '0;
                        predicted_rsp.push_back(mk_rsp(KIND_FIRE, pos, 1'b0));
                    end
                    pos = pos + 1'b1;
                end
                predicted_rsp.push_back(mk_rsp(KIND_ACK, '0, 1'b1));
            end
            default:
                predicted_rsp.push_back(mk_rsp(KIND_ACK, '0, 1'b1));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Request side. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // Hold the request until it is taken, then log what it should produce.
    // With lit_on set, the typed-in result replaces the prediction, while the
    // predictor still advances so later rows stay in step.
    task automatic issue_request(input ost_req_t r, input logic lit_on, input ost_rsp_t lit);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (r.func == FUNC_TICK)
        begin
            ticks_sent++;
            if (ring_count == QUEUE_DEPTH)
                full_ticks++;
        end
        timer_table_predict(r);
        if (lit_on)
            expected_rsp.push_back(lit);
        else
            foreach (predicted_rsp[k])
                expected_rsp.push_back(predicted_rsp[k]);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop start for a short burst, with junk on the payload that must be ignored.
    task automatic idle_gap();
        start <= 1'b0;
        req   <= mk_req(rnd_func(), rnd_slot(), $urandom, rnd_bit());
        repeat ($urandom_range(1, 3))
            @(negedge clk);
    endtask

    // Hold off until every pending result has come back.
    task automatic hold_until_drained();
        start <= 1'b0;
        @(negedge clk);
        while (expected_rsp.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_rand(input ost_req_t r, input logic quiet);
        issue_request(r, 1'b0, '0);
        if (!quiet && $urandom_range(0, 2) == 0)
            idle_gap();
    endtask

    // Mostly aim at occupied positions, so that starts and enables reach the scan.
    function automatic logic [SLOT_W-1:0] pick_slot();
        if (ring_count != 0 && $urandom_range(0, 4) != 0)
            return ring_head + SLOT_W'($urandom_range(0, ring_count - 1));
        return rnd_slot();
    endfunction

    function automatic logic [TICK_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom;
            2:       return -tick_now;           // wraps the deadline to zero
            3:       return '1;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] pick_tick();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return '1;
            2:       return '0;
            3:       return tick_now;
            default: return tick_now + $urandom_range(1, 30);
        endcase
    endfunction

    // Random sequences, mostly well formed: fill the ring, arm slots and tick,
    // drain it, with some stray and junk requests mixed in.
    task automatic run_random(input int upto, input logic gaps_on);
        int   pick;
        int   n;
        logic quiet;
        while (items_sent < upto)
        begin
            pick  = $urandom_range(0, 11);
            quiet = !gaps_on || ($urandom_range(0, 3) == 0);
            case (pick)
                0, 1:
                begin
                    // fill to the top, then one refused register
                    while (ring_count < QUEUE_DEPTH)
                        send_rand(mk_req(FUNC_REGISTER, rnd_slot(), $urandom,
                                         $urandom_range(0, 4) != 0), quiet);
                    send_rand(mk_req(FUNC_REGISTER, rnd_slot(), $urandom, rnd_bit()), quiet);
                end
                2:
                begin
                    // drain to empty, then one refused unregister
                    while (ring_count != 0)
                        send_rand(mk_req(FUNC_UNREGISTER, rnd_slot(), $urandom, rnd_bit()),
                                  quiet);
                    send_rand(mk_req(FUNC_UNREGISTER, rnd_slot(), $urandom, rnd_bit()), quiet);
                end
                3:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n)
                        send_rand(mk_req($urandom_range(0, 1) ? FUNC_REGISTER : FUNC_UNREGISTER,
                                         rnd_slot(), $urandom,
                                         $urandom_range(0, 3) != 0), quiet);
                end
                4, 5, 6, 7:
                begin
                    // arm a handful of slots, then advance time
                    n = $urandom_range(1, 8);
                    repeat (n)
                    begin
                        case ($urandom_range(0, 9))
                            0, 1:    send_rand(mk_req(FUNC_SET_ENABLE, pick_slot(), $urandom,
                                                      $urandom_range(0, 3) != 0), quiet);
                            2:       send_rand(mk_req(FUNC_STOP, pick_slot(), $urandom,
                                                      rnd_bit()), quiet);
                            default: send_rand(mk_req(FUNC_START, pick_slot(), pick_delay(),
                                                      rnd_bit()), quiet);
                        endcase
                    end
                    send_rand(mk_req(FUNC_TICK, rnd_slot(), pick_tick(), rnd_bit()), quiet);
                    if ($urandom_range(0, 2) == 0)
                        send_rand(mk_req(FUNC_TICK, rnd_slot(), pick_tick(), rnd_bit()), quiet);
                end
                8:
                    send_rand(mk_req(FUNC_TICK, rnd_slot(), pick_tick(), rnd_bit()), quiet);
                9:
                    send_rand(mk_req($urandom_range(0, 1) ? FUNC_STOP : FUNC_SET_ENABLE,
                                     rnd_slot(), $urandom, rnd_bit()),
                              quiet);
                default:
                    // junk: any code, any field, unknown codes included
                    send_rand(mk_req(rnd_func(), rnd_slot(), $urandom, rnd_bit()), quiet);
            endcase
            if (gaps_on && $urandom_range(0, 9) == 0)
                hold_until_drained();
        end
    endtask

    task automatic add_row(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                           input logic [TICK_W-1:0] v, input logic e, input logic has_lit,
                           input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] so);
        dir_row_t row;
        row.rq      = mk_req(f, s, v, e);
        row.has_lit = has_lit;
        row.lit     = mk_rsp(k, so, 1'b1);
        dir_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Result side: the block cannot be stalled, so take every strobed result
    // at the edge that ends its cycle and match it against the oldest entry.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1)
        begin
            if (rsp.kind == KIND_FIRE)
                fires_seen++;
            if (rsp.kind == KIND_REFUSED)
                refusals_seen++;
            if (expected_rsp.size() == 0)
                report_mismatch($sformatf("unexpected result kind=%0d slot=%0d last=%0d",
                                          rsp.kind, rsp.slot_out, rsp.last));
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", rsp.kind, want.kind));
                if (rsp.slot_out !== want.slot_out)
                    report_mismatch($sformatf("slot_out %0d, want %0d (kind %0d)",
                                              rsp.slot_out, want.slot_out, want.kind));
                if (rsp.last !== want.last)
                    report_mismatch($sformatf("last %0d, want %0d (kind %0d)",
                                              rsp.last, want.last, want.kind));
            end
        end
    end

    // Watchdog: bound the run well past the slowest legal schedule.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_rsp.size());
            $display("[one_shot_timer_table] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        req            = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        items_sent     = 0;
        ticks_sent     = 0;
        full_ticks     = 0;
        fires_seen     = 0;
        refusals_seen  = 0;
        ring_head      = '0;
        ring_tail      = '0;
        ring_count     = '0;
        tick_now       = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            tbl_deadline[i] = '0;
            tbl_enabled[i]  = 1'b0;
        end

        // Directed rows. A typed-in result is given where it is plain from
        // the reset state or the request itself; the rest are predicted.
        add_row(FUNC_UNREGISTER, 4'd0,  32'd0,          1'b0, 1'b1, KIND_REFUSED, 4'd0);
        add_row(FUNC_TICK,       4'd0,  32'd0,          1'b0, 1'b1, KIND_ACK,     4'd0);
        add_row(FUNC_REGISTER,   4'd0,  32'd0,          1'b1, 1'b1, KIND_ACK,     4'd0);
        add_row(FUNC_REGISTER,   4'd15, 32'hFFFF_FFFF,  1'b0, 1'b1, KIND_ACK,     4'd1);
        add_row(FUNC_START,      4'd0,  32'd10,         1'b0, 1'b1, KIND_ACK,     4'd0);
        add_row(FUNC_START,      4'd1,  32'hFFFF_FFFF,  1'b1, 1'b1, KIND_ACK,     4'd1);
        add_row(FUNC_SET_ENABLE, 4'd1,  32'd0,          1'b1, 1'b1, KIND_ACK,     4'd1);
        add_row(FUNC_TICK,       4'd0,  32'd11,         1'b0, 1'b0, KIND_ACK,     4'd0);
        add_row(FUNC_TICK,       4'd0,  32'hFFFF_FFFF,  1'b0, 1'b0, KIND_ACK,     4'd0);
        // start on top of the largest tick: the deadline wraps to zero
        add_row(FUNC_START,      4'd0,  32'd1,          1'b0, 1'b1, KIND_ACK,     4'd0);
        add_row(FUNC_SET_ENABLE, 4'd0,  32'd0,          1'b1, 1'b1, KIND_ACK,     4'd0);
        add_row(FUNC_TICK,       4'd0,  32'd0,          1'b0, 1'b0, KIND_ACK,     4'd0);
        // slot outside the occupied span is still written and acked
        add_row(FUNC_START,      4'd15, 32'd5,          1'b0, 1'b1, KIND_ACK,     4'd15);
        add_row(FUNC_STOP,       4'd1,  32'd0,          1'b0, 1'b1, KIND_ACK,     4'd1);
        add_row(FUNC_RSVD_A,     4'd9,  32'd123,        1'b0, 1'b1, KIND_ACK,     4'd0);
        add_row(FUNC_RSVD_B,     4'd15, 32'hFFFF_FFFF,  1'b1, 1'b1, KIND_ACK,     4'd0);
        add_row(FUNC_UNREGISTER, 4'd0,  32'd0,          1'b0, 1'b1, KIND_ACK,     4'd0);
        add_row(FUNC_UNREGISTER, 4'd0,  32'd0,          1'b0, 1'b1, KIND_ACK,     4'd1);
        add_row(FUNC_UNREGISTER, 4'd0,  32'd0,          1'b0, 1'b1, KIND_REFUSED, 4'd0);
        add_row(FUNC_REGISTER,   4'd0,  32'd0,          1'b1, 1'b1, KIND_ACK,     4'd2);
        add_row(FUNC_START,      4'd2,  32'd0,          1'b0, 1'b1, KIND_ACK,     4'd2);
        add_row(FUNC_START,      4'd2,  32'd3,          1'b0, 1'b1, KIND_ACK,     4'd2);
        add_row(FUNC_TICK,       4'd0,  32'd3,          1'b0, 1'b0, KIND_ACK,     4'd0);
        add_row(FUNC_TICK,       4'd0,  32'd4,          1'b0, 1'b0, KIND_ACK,     4'd0);

        // Hold reset, then release it away from the rising edge.
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table back to back.
        foreach (dir_rows[i])
            issue_request(dir_rows[i].rq, dir_rows[i].has_lit, dir_rows[i].lit);
        hold_until_drained();

        // Random sequences with idle bursts, then a stretch with none.
        run_random(GAP_ITEMS, 1'b1);
        run_random(TOTAL_ITEMS, 1'b0);

        // Drain, then allow for a scan still in flight.
        hold_until_drained();
        repeat (SCAN_SETTLE)
            @(posedge clk);

        $display("covered %0d requests incl. %0d ticks (%0d on a full ring)",
                 items_sent, ticks_sent, full_ticks);
        $display("saw %0d fires and %0d refusals, %0d mismatches",
                 fires_seen, refusals_seen, mismatch_count);
        if (mismatch_count == 0 && expected_rsp.size() == 0)
            $display("[one_shot_timer_table] OK");
        else
            $display("[one_shot_timer_table] ERROR");
        $finish;
    end

endmodule
